// ===== hdl/dual_motor_speed_ramp_macros.svh =====
// Assertion macros for the dual motor speed ramp block.
// Included by the top level; depends on nothing else.
`ifndef DUAL_MOTOR_SPEED_RAMP_MACROS_SVH
`define DUAL_MOTOR_SPEED_RAMP_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define DSR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define DSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/dsr_pkg.sv =====
// Shared types and constants of the dual motor speed ramp block.
// Used by the divider, the motor lane and the top level; depends on nothing.
package dsr_pkg;

	// Ramp tick period in milliseconds
	localparam int unsigned TICK_MS = 50;

	// Speed and operand width
	localparam int unsigned SPEED_W = 16;

	// Restoring divider: one quotient bit per cycle
	localparam int unsigned DIV_STEPS = SPEED_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// Tick count by reciprocal multiply: exact for every ramp time of SPEED_W bits
	localparam int unsigned RECIP_SHIFT = SPEED_W + $clog2(TICK_MS);
	localparam int unsigned RECIP_K     = ((1 << RECIP_SHIFT) + TICK_MS - 1) / TICK_MS;
	localparam int unsigned PROD_W      = RECIP_SHIFT + SPEED_W;

	typedef logic [SPEED_W-1:0] speed_t;
	typedef logic signed [SPEED_W:0] step_t;

	// Top level to lane: start a tick, release the result
	typedef struct packed {
		logic start;
		logic ack;
	} lane_ctl_t;

	// Lane to top level: finished tick and its fields
	typedef struct packed {
		logic   done;
		logic   dir_write;
		logic   dir_out;
		logic   speed_write;
		speed_t speed;
	} lane_res_t;

endpackage

// ===== hdl/dsr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on dsr_pkg for the operand width and step count.
module dsr_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dsr_pkg::speed_t dividend,
	input  dsr_pkg::speed_t divisor,
	output logic            done,
	output dsr_pkg::speed_t quotient
);

	dsr_pkg::speed_t                 rem_q;
	dsr_pkg::speed_t                 work_q;
	dsr_pkg::speed_t                 dvs_q;
	logic [dsr_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [dsr_pkg::SPEED_W:0] shifted;
	logic                      ge;

	// Shift in the next dividend bit and trial-subtract
	always_comb begin
		shifted = {rem_q, work_q[dsr_pkg::SPEED_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
	end

	// Control: count steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dsr_pkg::DIV_CNT_W'(dsr_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			work_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? dsr_pkg::SPEED_W'(shifted - {1'b0, dvs_q})
			             : shifted[dsr_pkg::SPEED_W-1:0];
			work_q <= {work_q[dsr_pkg::SPEED_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

// ===== hdl/dsr_lane.sv =====
// One motor lane: target tracking, step computation and speed ramping.
// Depends on dsr_pkg and instantiates dsr_div for the step division.
module dsr_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  dsr_pkg::lane_ctl_t  ctl,
	input  dsr_pkg::speed_t     req_target,
	input  dsr_pkg::speed_t     req_ramp,
	input  logic                req_dir,
	output dsr_pkg::lane_res_t  res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_S,
		ST_MOVE,
		ST_DONE
	} lane_state_t;

	lane_state_t     state_q;
	dsr_pkg::speed_t target_q;
	dsr_pkg::speed_t present_q;
	dsr_pkg::step_t  step_q;
	logic            neg_q;
	logic            dir_w_q;
	logic            dir_o_q;
	logic            spd_w_q;
	logic            div_go_q;
	dsr_pkg::speed_t div_a_q;
	dsr_pkg::speed_t div_b_q;

	logic                      div_done;
	dsr_pkg::speed_t           div_quo;
	dsr_pkg::speed_t           quo_nz;
	logic [dsr_pkg::PROD_W-1:0] ramp_prod;
	dsr_pkg::speed_t           ticks;
	dsr_pkg::speed_t           ticks_nz;
	logic signed [dsr_pkg::SPEED_W+1:0] diff;
	logic signed [dsr_pkg::SPEED_W+1:0] nxt;
	logic signed [dsr_pkg::SPEED_W+1:0] tgt_s;
	dsr_pkg::step_t            step_v;

	dsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Divide the ramp time by the tick period with a reciprocal multiply
	always_comb begin
		ramp_prod = dsr_pkg::PROD_W'(req_ramp) * dsr_pkg::PROD_W'(dsr_pkg::RECIP_K);
		ticks     = dsr_pkg::SPEED_W'(ramp_prod >> dsr_pkg::RECIP_SHIFT);
		ticks_nz  = (ticks == '0) ? dsr_pkg::SPEED_W'(1) : ticks;
	end

	// Raise a zero quotient to one; form difference and next speed
	always_comb begin
		quo_nz = (div_quo == '0) ? dsr_pkg::SPEED_W'(1) : div_quo;
		diff   = $signed({2'b00, req_target}) - $signed({2'b00, present_q});
		tgt_s  = $signed({2'b00, target_q});
		if (step_q == '0)
			step_v = (target_q > present_q) ? dsr_pkg::step_t'(1) : -dsr_pkg::step_t'(1);
		else
			step_v = step_q;
		nxt = $signed({2'b00, present_q}) + {step_v[dsr_pkg::SPEED_W], step_v};
		if ((step_v > 0 && nxt > tgt_s) || (step_v < 0 && nxt < tgt_s))
			nxt = tgt_s;
		if (nxt < 0)
			nxt = '0;
		if (nxt > $signed({2'b00, {dsr_pkg::SPEED_W{1'b1}}}))
			nxt = $signed({2'b00, {dsr_pkg::SPEED_W{1'b1}}});
	end

	// Sequence one tick through the divider, when a step is needed, and the move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			target_q  <= '0;
			present_q <= '0;
			step_q    <= '0;
			neg_q     <= 1'b0;
			div_go_q  <= 1'b0;
			div_a_q   <= '0;
			div_b_q   <= '0;
			dir_w_q   <= 1'b0;
			dir_o_q   <= 1'b0;
			spd_w_q   <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						if (req_target != target_q) begin
							target_q <= req_target;
							dir_w_q  <= 1'b1;
							dir_o_q  <= req_dir;
							if (diff == '0) begin
								step_q  <= '0;
								state_q <= ST_MOVE;
							end else begin
								neg_q    <= diff < 0;
								div_a_q  <= dsr_pkg::SPEED_W'((diff < 0) ? -diff : diff);
								div_b_q  <= ticks_nz;
								div_go_q <= 1'b1;
								state_q  <= ST_DIV_S;
							end
						end else begin
							dir_w_q <= 1'b0;
							dir_o_q <= 1'b0;
							state_q <= ST_MOVE;
						end
					end
				end
				ST_DIV_S: begin
					if (div_done) begin
						step_q  <= neg_q ? -$signed({1'b0, quo_nz}) : $signed({1'b0, quo_nz});
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					if (present_q != target_q) begin
						present_q <= dsr_pkg::SPEED_W'(nxt);
						spd_w_q   <= 1'b1;
					end else begin
						spd_w_q <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ctl.ack)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.done        = state_q == ST_DONE;
	assign res.dir_write   = dir_w_q;
	assign res.dir_out     = dir_o_q;
	assign res.speed_write = spd_w_q;
	assign res.speed       = present_q;

endmodule

// ===== hdl/dual_motor_speed_ramp.sv =====
// Dual motor speed ramp: one tick in, one result beat out, both motors in parallel lanes.
// Each lane moves its speed and then reaches done; the merge registers both results and
// raises out_valid. A new target that needs a step first gets it from one 16-step serial
// division of the distance by the ticks. The input stays closed until the merge.
// A result waiting at the output register does not block the next tick's work.
// Reset (arst_n low, asynchronous) zeroes targets, speeds and steps and empties the output.
`include "dual_motor_speed_ramp_macros.svh"

module dual_motor_speed_ramp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dsr_pkg::speed_t target_left,
	input  dsr_pkg::speed_t target_right,
	input  dsr_pkg::speed_t ramp_ms_left,
	input  dsr_pkg::speed_t ramp_ms_right,
	input  logic            dir_left,
	input  logic            dir_right,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            dir_write_left,
	output logic            dir_out_left,
	output logic            dir_write_right,
	output logic            dir_out_right,
	output logic            speed_write_left,
	output dsr_pkg::speed_t speed_out_left,
	output logic            speed_write_right,
	output dsr_pkg::speed_t speed_out_right
);

	logic               busy_q;
	logic               out_valid_q;
	dsr_pkg::lane_res_t out_l_q;
	dsr_pkg::lane_res_t out_r_q;

	dsr_pkg::lane_ctl_t ctl;
	dsr_pkg::lane_res_t res_l;
	dsr_pkg::lane_res_t res_r;
	logic               accept;
	logic               load;

	// Start lanes on an input beat; merge once both lanes finish and the output is free
	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	assign load      = busy_q && res_l.done && res_r.done && (!out_valid_q || out_ready);
	assign ctl.start = accept;
	assign ctl.ack   = load;

	dsr_lane u_lane_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.req_target (target_left),
		.req_ramp   (ramp_ms_left),
		.req_dir    (dir_left),
		.res        (res_l)
	);

	dsr_lane u_lane_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.req_target (target_right),
		.req_ramp   (ramp_ms_right),
		.req_dir    (dir_right),
		.res        (res_r)
	);

	// Hold busy while lanes work; hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (load)
				busy_q <= 1'b0;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Capture both lanes' fields into the output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_l_q <= res_l;
			out_r_q <= res_r;
		end
	end

	assign out_valid         = out_valid_q;
	assign dir_write_left    = out_l_q.dir_write;
	assign dir_out_left      = out_l_q.dir_out;
	assign dir_write_right   = out_r_q.dir_write;
	assign dir_out_right     = out_r_q.dir_out;
	assign speed_write_left  = out_l_q.speed_write;
	assign speed_out_left    = out_l_q.speed;
	assign speed_write_right = out_r_q.speed_write;
	assign speed_out_right   = out_r_q.speed;

	// Accepted tick keeps the input closed until the merge
	`DSR_ASSERT_NEXT(a_accept_closes, accept, !in_ready)
	// Lanes are idle whenever a new tick can enter
	`DSR_ASSERT_SAME(a_idle_lanes, in_ready, !res_l.done && !res_r.done)
	// A direction value only travels with a direction write
	`DSR_ASSERT_SAME(a_dir_left, out_valid && dir_out_left, dir_write_left)
	`DSR_ASSERT_SAME(a_dir_right, out_valid && dir_out_right, dir_write_right)

endmodule
